### hdl/fmmr_pkg.sv
// -----------------------------------------------------------------------------
// fmmr_pkg
// Types, constants and the control store of the fraction min/max reducer.
// -----------------------------------------------------------------------------
package fmmr_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int K_W         = $clog2(VALUE_WIDTH);
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
	localparam int PROD_W      = 2 * VALUE_WIDTH + 2;
	localparam int PC_W        = 5;

	localparam logic [VALUE_WIDTH-1:0] HALF_MAG = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [VALUE_WIDTH-1:0] POS_MAX  = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

	typedef struct packed {
		logic [0:0]                    opcode;
		logic signed [VALUE_WIDTH-1:0] numerator_in;
		logic signed [VALUE_WIDTH-1:0] denominator_in;
	} in_item_t;

	typedef struct packed {
		logic                          empty_res;
		logic signed [VALUE_WIDTH-1:0] max_numerator;
		logic signed [VALUE_WIDTH-1:0] max_denominator;
		logic signed [VALUE_WIDTH-1:0] max_reduced_numerator;
		logic [VALUE_WIDTH-1:0]        max_reduced_denominator;
		logic signed [VALUE_WIDTH-1:0] min_numerator;
		logic signed [VALUE_WIDTH-1:0] min_denominator;
		logic signed [VALUE_WIDTH-1:0] min_reduced_numerator;
		logic [VALUE_WIDTH-1:0]        min_reduced_denominator;
		logic                          zero_denominator_seen;
	} out_item_t;

	localparam logic [0:0] OPC_SUBMIT = 1'b0;
	localparam logic [0:0] OPC_REPORT = 1'b1;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_MUL_L,
		OP_MUL_R,
		OP_SET_FIRST,
		OP_SET_TRACK,
		OP_SET_BAD,
		OP_GCD_INIT,
		OP_GCD_STEP,
		OP_DIV_INIT_N,
		OP_DIV_INIT_D,
		OP_DIV_STEP,
		OP_SAVE_N,
		OP_SAVE_D,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_ZERO_DEN,
		C_SEEN,
		C_GT,
		C_LT,
		C_GCD_DONE,
		C_DIV_DONE
	} cond_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_GOTO,
		J_IF_SET,
		J_IF_CLR,
		J_DISPATCH
	} jump_t;

	typedef struct packed {
		op_t              op;
		logic             sel_min;
		jump_t            jmp;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} ucode_t;

	// datapath control for one step
	typedef struct packed {
		logic load;
		op_t  op;
		logic sel_min;
	} dp_ctl_t;

	// datapath status tested by jumps
	typedef struct packed {
		logic zero_den;
		logic seen;
		logic gt;
		logic lt;
		logic gcd_done;
		logic div_done;
	} dp_flags_t;

	// control store addresses
	localparam logic [PC_W-1:0] A_IDLE      = 5'd0;
	localparam logic [PC_W-1:0] A_SUB       = 5'd1;
	localparam logic [PC_W-1:0] A_SUB_SEEN  = 5'd2;
	localparam logic [PC_W-1:0] A_MAX_L     = 5'd3;
	localparam logic [PC_W-1:0] A_MAX_R     = 5'd4;
	localparam logic [PC_W-1:0] A_MAX_CMP   = 5'd5;
	localparam logic [PC_W-1:0] A_MIN_L     = 5'd6;
	localparam logic [PC_W-1:0] A_MIN_R     = 5'd7;
	localparam logic [PC_W-1:0] A_MIN_CMP   = 5'd8;
	localparam logic [PC_W-1:0] A_SET_MIN   = 5'd9;
	localparam logic [PC_W-1:0] A_SET_MAX   = 5'd10;
	localparam logic [PC_W-1:0] A_FIRST     = 5'd11;
	localparam logic [PC_W-1:0] A_BAD       = 5'd12;
	localparam logic [PC_W-1:0] A_RPT       = 5'd13;
	localparam logic [PC_W-1:0] A_MAX_GI    = 5'd14;
	localparam logic [PC_W-1:0] A_MAX_GS    = 5'd15;
	localparam logic [PC_W-1:0] A_MAX_DIN   = 5'd16;
	localparam logic [PC_W-1:0] A_MAX_DSN   = 5'd17;
	localparam logic [PC_W-1:0] A_MAX_SN    = 5'd18;
	localparam logic [PC_W-1:0] A_MAX_DID   = 5'd19;
	localparam logic [PC_W-1:0] A_MAX_DSD   = 5'd20;
	localparam logic [PC_W-1:0] A_MAX_SD    = 5'd21;
	localparam logic [PC_W-1:0] A_MIN_GI    = 5'd22;
	localparam logic [PC_W-1:0] A_MIN_GS    = 5'd23;
	localparam logic [PC_W-1:0] A_MIN_DIN   = 5'd24;
	localparam logic [PC_W-1:0] A_MIN_DSN   = 5'd25;
	localparam logic [PC_W-1:0] A_MIN_SN    = 5'd26;
	localparam logic [PC_W-1:0] A_MIN_DID   = 5'd27;
	localparam logic [PC_W-1:0] A_MIN_DSD   = 5'd28;
	localparam logic [PC_W-1:0] A_MIN_SD    = 5'd29;
	localparam logic [PC_W-1:0] A_EMIT      = 5'd30;

	function automatic ucode_t uw(op_t op, logic sel, jump_t j, cond_t c,
		logic [PC_W-1:0] t);
		return '{op, sel, j, c, t};
	endfunction

	// control store: one word per step
	function automatic ucode_t ucode(logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			A_IDLE:     w = uw(OP_NOP,        1'b0, J_DISPATCH, C_SEEN,     A_IDLE);
			A_SUB:      w = uw(OP_NOP,        1'b0, J_IF_SET,   C_ZERO_DEN, A_BAD);
			A_SUB_SEEN: w = uw(OP_NOP,        1'b0, J_IF_CLR,   C_SEEN,     A_FIRST);
			A_MAX_L:    w = uw(OP_MUL_L,      1'b0, J_NEXT,     C_SEEN,     A_IDLE);
			A_MAX_R:    w = uw(OP_MUL_R,      1'b0, J_NEXT,     C_SEEN,     A_IDLE);
			A_MAX_CMP:  w = uw(OP_NOP,        1'b0, J_IF_SET,   C_GT,       A_SET_MAX);
			A_MIN_L:    w = uw(OP_MUL_L,      1'b1, J_NEXT,     C_SEEN,     A_IDLE);
			A_MIN_R:    w = uw(OP_MUL_R,      1'b1, J_NEXT,     C_SEEN,     A_IDLE);
			A_MIN_CMP:  w = uw(OP_NOP,        1'b1, J_IF_CLR,   C_LT,       A_IDLE);
			A_SET_MIN:  w = uw(OP_SET_TRACK,  1'b1, J_GOTO,     C_SEEN,     A_IDLE);
			A_SET_MAX:  w = uw(OP_SET_TRACK,  1'b0, J_GOTO,     C_SEEN,     A_IDLE);
			A_FIRST:    w = uw(OP_SET_FIRST,  1'b0, J_GOTO,     C_SEEN,     A_IDLE);
			A_BAD:      w = uw(OP_SET_BAD,    1'b0, J_GOTO,     C_SEEN,     A_IDLE);
			A_RPT:      w = uw(OP_NOP,        1'b0, J_IF_CLR,   C_SEEN,     A_EMIT);
			A_MAX_GI:   w = uw(OP_GCD_INIT,   1'b0, J_NEXT,     C_SEEN,     A_IDLE);
			A_MAX_GS:   w = uw(OP_GCD_STEP,   1'b0, J_IF_CLR,   C_GCD_DONE, A_MAX_GS);
			A_MAX_DIN:  w = uw(OP_DIV_INIT_N, 1'b0, J_NEXT,     C_SEEN,     A_IDLE);
			A_MAX_DSN:  w = uw(OP_DIV_STEP,   1'b0, J_IF_CLR,   C_DIV_DONE, A_MAX_DSN);
			A_MAX_SN:   w = uw(OP_SAVE_N,     1'b0, J_NEXT,     C_SEEN,     A_IDLE);
			A_MAX_DID:  w = uw(OP_DIV_INIT_D, 1'b0, J_NEXT,     C_SEEN,     A_IDLE);
			A_MAX_DSD:  w = uw(OP_DIV_STEP,   1'b0, J_IF_CLR,   C_DIV_DONE, A_MAX_DSD);
			A_MAX_SD:   w = uw(OP_SAVE_D,     1'b0, J_NEXT,     C_SEEN,     A_IDLE);
			A_MIN_GI:   w = uw(OP_GCD_INIT,   1'b1, J_NEXT,     C_SEEN,     A_IDLE);
			A_MIN_GS:   w = uw(OP_GCD_STEP,   1'b1, J_IF_CLR,   C_GCD_DONE, A_MIN_GS);
			A_MIN_DIN:  w = uw(OP_DIV_INIT_N, 1'b1, J_NEXT,     C_SEEN,     A_IDLE);
			A_MIN_DSN:  w = uw(OP_DIV_STEP,   1'b1, J_IF_CLR,   C_DIV_DONE, A_MIN_DSN);
			A_MIN_SN:   w = uw(OP_SAVE_N,     1'b1, J_NEXT,     C_SEEN,     A_IDLE);
			A_MIN_DID:  w = uw(OP_DIV_INIT_D, 1'b1, J_NEXT,     C_SEEN,     A_IDLE);
			A_MIN_DSD:  w = uw(OP_DIV_STEP,   1'b1, J_IF_CLR,   C_DIV_DONE, A_MIN_DSD);
			A_MIN_SD:   w = uw(OP_SAVE_D,     1'b1, J_NEXT,     C_SEEN,     A_IDLE);
			A_EMIT:     w = uw(OP_EMIT,       1'b0, J_GOTO,     C_SEEN,     A_IDLE);
			default:    w = uw(OP_NOP,        1'b0, J_GOTO,     C_SEEN,     A_IDLE);
		endcase
		return w;
	endfunction

endpackage

### hdl/fraction_min_max_reducer.sv
// -----------------------------------------------------------------------------
// fraction_min_max_reducer
// Running min/max of signed fractions with binary-GCD reduction on report.
// -----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low. opcode 0
//   submits numerator_in/denominator_in; opcode 1 asks for a report.
//   A submit yields no result and keeps busy high until it is through: a zero
//   denominator ends it soonest, then the first fraction, and it runs longest
//   when both the largest and the smallest are compared (two products each,
//   one shared multiplier). A report yields one result beat: done is high for
//   exactly one cycle with the beat on result. An empty report skips the
//   reduction; otherwise the binary GCD loop and two bit-serial divisions run
//   for each of the two fractions. done rises in the cycle busy falls, so the
//   next item may be taken in that same cycle. The receiver cannot stall; the
//   result register holds until the next report. After reset the tracker is
//   empty and the flags are clear; a report also clears them.
// -----------------------------------------------------------------------------
module fraction_min_max_reducer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  fmmr_pkg::in_item_t   item,
	output logic                 done,
	output fmmr_pkg::out_item_t  result
);
	import fmmr_pkg::*;

	localparam int W = VALUE_WIDTH;

	dp_ctl_t   ctl;
	dp_flags_t flags;

	// captured item, raw and with the denominator made positive
	logic signed [W-1:0] in_num_q, in_den_q;
	logic signed [W:0]   in_nn_q, in_dn_q;
	logic signed [W:0]   nx, dx, nn_d, dn_d;

	// tracker
	logic                seen_q, bad_q;
	logic signed [W-1:0] lg_num_q, lg_den_q, sm_num_q, sm_den_q;
	logic signed [W:0]   lg_nn_q, lg_dn_q, sm_nn_q, sm_dn_q;

	// compare products
	logic signed [PROD_W-1:0] pl_q, pr_q;
	logic signed [W:0]        mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;

	// gcd and divider
	logic [W-1:0]     u_q, v_q, div_q, rem_q, quo_q;
	logic [K_W-1:0]   k_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W:0]       trial, diff;

	// reduced forms
	logic [W-1:0] max_rn_q, max_rd_q, min_rn_q, min_rd_q;

	logic                done_q;
	out_item_t           result_q;

	logic signed [W-1:0] sel_num, sel_den;
	logic signed [W:0]   sel_nn, sel_dn;
	logic [W-1:0]        num_mag, den_mag, rn_val;
	logic                neg;

	fmmr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (item.opcode),
		.flags  (flags),
		.busy   (busy),
		.ctl    (ctl)
	);

	assign nx   = {item.numerator_in[W-1], item.numerator_in};
	assign dx   = {item.denominator_in[W-1], item.denominator_in};
	assign nn_d = item.denominator_in[W-1] ? -nx : nx;
	assign dn_d = item.denominator_in[W-1] ? -dx : dx;

	assign sel_num = ctl.sel_min ? sm_num_q : lg_num_q;
	assign sel_den = ctl.sel_min ? sm_den_q : lg_den_q;
	assign sel_nn  = ctl.sel_min ? sm_nn_q : lg_nn_q;
	assign sel_dn  = ctl.sel_min ? sm_dn_q : lg_dn_q;

	// one multiplier serves both cross products
	assign mul_a = (ctl.op == OP_MUL_L) ? in_nn_q : sel_nn;
	assign mul_b = (ctl.op == OP_MUL_L) ? sel_dn : in_dn_q;
	assign prod  = mul_a * mul_b;

	assign num_mag = sel_num[W-1] ? (~sel_num + 1'b1) : sel_num;
	assign den_mag = sel_den[W-1] ? (~sel_den + 1'b1) : sel_den;

	// sign goes on the numerator; a positive 2^(W-1) saturates
	assign neg    = sel_num[W-1] ^ sel_den[W-1];
	assign rn_val = neg ? (~quo_q + 1'b1) : ((quo_q == HALF_MAG) ? POS_MAX : quo_q);

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, div_q};

	assign flags.zero_den = (in_den_q == '0);
	assign flags.seen     = seen_q;
	assign flags.gt       = (pl_q > pr_q);
	assign flags.lt       = (pl_q < pr_q);
	assign flags.gcd_done = (u_q == '0);
	assign flags.div_done = (cnt_q == '0);

	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			bad_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= (ctl.op == OP_EMIT);
			case (ctl.op)
				OP_SET_FIRST: seen_q <= 1'b1;
				OP_SET_BAD:   bad_q  <= 1'b1;
				OP_EMIT: begin
					seen_q <= 1'b0;
					bad_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			in_num_q <= item.numerator_in;
			in_den_q <= item.denominator_in;
			in_nn_q  <= nn_d;
			in_dn_q  <= dn_d;
		end
		case (ctl.op)
			OP_MUL_L: pl_q <= prod;
			OP_MUL_R: pr_q <= prod;
			OP_SET_FIRST: begin
				lg_num_q <= in_num_q;
				lg_den_q <= in_den_q;
				lg_nn_q  <= in_nn_q;
				lg_dn_q  <= in_dn_q;
				sm_num_q <= in_num_q;
				sm_den_q <= in_den_q;
				sm_nn_q  <= in_nn_q;
				sm_dn_q  <= in_dn_q;
			end
			OP_SET_TRACK: begin
				if (ctl.sel_min) begin
					sm_num_q <= in_num_q;
					sm_den_q <= in_den_q;
					sm_nn_q  <= in_nn_q;
					sm_dn_q  <= in_dn_q;
				end else begin
					lg_num_q <= in_num_q;
					lg_den_q <= in_den_q;
					lg_nn_q  <= in_nn_q;
					lg_dn_q  <= in_dn_q;
				end
			end
			OP_GCD_INIT: begin
				u_q <= num_mag;
				v_q <= den_mag;
				k_q <= '0;
			end
			OP_GCD_STEP: begin
				// binary gcd: drop common twos, strip lone twos, subtract odds
				if (u_q != '0) begin
					if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + 1'b1;
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (u_q >= v_q) begin
						u_q <= (u_q - v_q) >> 1;
					end else begin
						v_q <= (v_q - u_q) >> 1;
					end
				end
			end
			OP_DIV_INIT_N: begin
				div_q <= v_q << k_q;
				quo_q <= num_mag;
				rem_q <= '0;
				cnt_q <= CNT_W'(W);
			end
			OP_DIV_INIT_D: begin
				div_q <= v_q << k_q;
				quo_q <= den_mag;
				rem_q <= '0;
				cnt_q <= CNT_W'(W);
			end
			OP_DIV_STEP: begin
				// restoring division, one quotient bit per cycle
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
					if (!diff[W]) begin
						rem_q <= diff[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b1};
					end else begin
						rem_q <= trial[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b0};
					end
				end
			end
			OP_SAVE_N: begin
				if (ctl.sel_min)
					min_rn_q <= rn_val;
				else
					max_rn_q <= rn_val;
			end
			OP_SAVE_D: begin
				if (ctl.sel_min)
					min_rd_q <= quo_q;
				else
					max_rd_q <= quo_q;
			end
			OP_EMIT: begin
				result_q.empty_res             <= !seen_q;
				result_q.zero_denominator_seen <= bad_q;
				if (seen_q) begin
					result_q.max_numerator           <= lg_num_q;
					result_q.max_denominator         <= lg_den_q;
					result_q.max_reduced_numerator   <= max_rn_q;
					result_q.max_reduced_denominator <= max_rd_q;
					result_q.min_numerator           <= sm_num_q;
					result_q.min_denominator         <= sm_den_q;
					result_q.min_reduced_numerator   <= min_rn_q;
					result_q.min_reduced_denominator <= min_rd_q;
				end else begin
					result_q.max_numerator           <= '0;
					result_q.max_denominator         <= W'(1);
					result_q.max_reduced_numerator   <= '0;
					result_q.max_reduced_denominator <= W'(1);
					result_q.min_numerator           <= '0;
					result_q.min_denominator         <= W'(1);
					result_q.min_reduced_numerator   <= '0;
					result_q.min_reduced_denominator <= W'(1);
				end
			end
			default: ;
		endcase
	end

	a_done_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctl.op == OP_EMIT))
		else $error("result beat without a report step");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_EMIT) |=> (!seen_q && !bad_q))
		else $error("tracker not cleared after report");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.empty_res) |->
		(result.max_reduced_denominator != '0 && result.min_reduced_denominator != '0))
		else $error("reduced denominator is zero");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_DIV_STEP && cnt_q != '0) |-> (div_q != '0))
		else $error("division by zero gcd");

endmodule

### hdl/fmmr_seq.sv
// -----------------------------------------------------------------------------
// fmmr_seq
// Step counter and control store; issues one control word per cycle.
// -----------------------------------------------------------------------------
module fmmr_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [0:0]          opcode,
	input  fmmr_pkg::dp_flags_t flags,
	output logic                busy,
	output fmmr_pkg::dp_ctl_t   ctl
);
	import fmmr_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	ucode_t          w;
	logic            cond_val;
	logic            accept;

	assign w      = ucode(pc_q);
	assign busy   = (pc_q != A_IDLE);
	assign accept = start && !busy;

	assign ctl.load    = accept;
	assign ctl.op      = w.op;
	assign ctl.sel_min = w.sel_min;

	always_comb begin
		case (w.cond)
			C_ZERO_DEN: cond_val = flags.zero_den;
			C_SEEN:     cond_val = flags.seen;
			C_GT:       cond_val = flags.gt;
			C_LT:       cond_val = flags.lt;
			C_GCD_DONE: cond_val = flags.gcd_done;
			C_DIV_DONE: cond_val = flags.div_done;
			default:    cond_val = 1'b0;
		endcase
	end

	always_comb begin
		case (w.jmp)
			J_NEXT:     pc_next = pc_q + 1'b1;
			J_GOTO:     pc_next = w.target;
			J_IF_SET:   pc_next = cond_val ? w.target : pc_q + 1'b1;
			J_IF_CLR:   pc_next = cond_val ? pc_q + 1'b1 : w.target;
			J_DISPATCH: begin
				if (!accept)
					pc_next = A_IDLE;
				else if (opcode == OPC_REPORT)
					pc_next = A_RPT;
				else
					pc_next = A_SUB;
			end
			default:    pc_next = A_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= A_IDLE;
		else
			pc_q <= pc_next;
	end

endmodule
